// File: rtl/frame_aligned_packet_placer_assert.svh
// Assertion macros for the frame aligned packet placer.
// Expects signals clk and rst_n in the scope of each use.
`ifndef FRAME_ALIGNED_PACKET_PLACER_ASSERT_SVH
`define FRAME_ALIGNED_PACKET_PLACER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define FAPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define FAPP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fapp_pkg.sv
// Shared types and constants of the frame aligned packet placer.
// No dependencies; every RTL module imports this package.
`default_nettype none

package fapp_pkg;

    // Field and register widths
    localparam int SEQ_W      = 32;
    localparam int PKT_W      = 14;
    localparam int FRM_W      = 25;
    localparam int FCNT_W     = 8;
    localparam int OFF_W      = 32;
    localparam int SRC_W      = 13;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // Header length default and register limits
    localparam int unsigned HEADER_BYTES_DEF = 10;
    localparam logic [PKT_W-1:0] PKT_MAX   = 14'd8192;
    localparam logic [FRM_W-1:0] FRAME_MAX = 25'd16777216;

    // Register reset values
    localparam logic [PKT_W-1:0]  PKT_RST   = 14'd1466;
    localparam logic [FRM_W-1:0]  FRM_RST   = 25'd65536;
    localparam logic [FCNT_W-1:0] FCNT_RST  = 8'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Iterative divider: dividend, divisor, bits retired per cycle
    localparam int DIV_DVD_W = 48;
    localparam int DIV_DVS_W = 25;
    localparam int DIV_STEP  = 3;
    localparam int DIV_ITER  = DIV_DVD_W / DIV_STEP;

    typedef struct packed {
        logic [PKT_W-1:0]  packet_bytes;
        logic [FRM_W-1:0]  frame_bytes;
        logic [FCNT_W-1:0] frame_count;
    } cfg_t;

    // One classified packet beat; work is low for beats that are ignored
    typedef struct packed {
        logic             work;
        logic [SEQ_W-1:0] seq;
    } item_t;

    typedef struct packed {
        logic             place_valid;
        logic [OFF_W-1:0] dest_offset;
        logic [SRC_W-1:0] src_offset;
        logic [LEN_W-1:0] copy_length;
        logic             synced_now;
        logic             capture_done;
    } res_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quo;
        logic [DIV_DVS_W-1:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/fapp_front.sv
// Input stage: takes packet beats and tags those that need work.
// Depends on fapp_pkg.
`default_nettype none

module fapp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [fapp_pkg::SEQ_W-1:0]  seq_num,
    input  fapp_pkg::cfg_t              cfg,
    output logic                        full,
    output logic                        item_valid,
    output fapp_pkg::item_t             item,
    input  logic                        sink_ready
);
    import fapp_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  accept, handoff;

    assign handoff    = valid_reg && sink_ready;
    assign full       = valid_reg && !sink_ready;
    assign accept     = push && !full;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Stage occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (handoff)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Sequence zero and odd packet lengths pass through as no-work beats
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.work <= (seq_num != '0) && !cfg.packet_bytes[0];
            item_reg.seq  <= seq_num;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fapp_queue.sv
// Short FIFO that decouples the input stage from the placement engine.
// Depends on fapp_pkg.
`default_nettype none

module fapp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  fapp_pkg::item_t wr_item,
    output logic            full,
    input  logic            rd_en,
    output fapp_pkg::item_t rd_item,
    output logic            empty
);
    import fapp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full    = (cnt_reg == DEPTH_C);
    assign empty   = (cnt_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fapp_div.sv
// Restoring divider, DIV_STEP quotient bits per cycle; gives quotient and remainder.
// Depends on fapp_pkg.
`default_nettype none

module fapp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fapp_pkg::div_req_t req,
    output fapp_pkg::div_rsp_t rsp
);
    import fapp_pkg::*;

    localparam int CNT_W = $clog2(DIV_ITER + 1);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    // dividend bits shift out at the top, quotient bits shift in at the bottom
    logic [DIV_DVD_W-1:0] dvd_reg, dvd_step;
    logic [DIV_DVS_W-1:0] rem_reg, rem_step;
    logic [DIV_DVS_W-1:0] dsr_reg;

    assign rsp.done = done_reg;
    assign rsp.quo  = dvd_reg;
    assign rsp.rem  = rem_reg;

    // DIV_STEP shift-subtract steps per cycle
    always_comb
    begin
        logic [DIV_DVS_W:0]   trial;
        logic [DIV_DVS_W-1:0] rem_v;
        logic [DIV_DVD_W-1:0] dvd_v;
        rem_v = rem_reg;
        dvd_v = dvd_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_v, dvd_v[DIV_DVD_W-1]};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
                dvd_v = {dvd_v[DIV_DVD_W-2:0], 1'b1};
            end
            else
            begin
                dvd_v = {dvd_v[DIV_DVD_W-2:0], 1'b0};
            end
            rem_v = trial[DIV_DVS_W-1:0];
        end
        rem_step = rem_v;
        dvd_step = dvd_v;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_ITER);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_step;
            rem_reg <= rem_step;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fapp_back.sv
// Placement engine: sync search, capture tracking and the result register.
// Depends on fapp_pkg and uses one fapp_div through its request/response structs.
`default_nettype none

module fapp_back #(
    parameter int unsigned HEADER_BYTES = fapp_pkg::HEADER_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fapp_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  fapp_pkg::item_t    q_item,
    output logic               q_pop,
    output fapp_pkg::div_req_t div_req,
    input  fapp_pkg::div_rsp_t div_rsp,
    output logic               res_valid,
    output fapp_pkg::res_t     res,
    input  logic               res_pop
);
    import fapp_pkg::*;

    localparam int PROD_W = SEQ_W + LEN_W;
    localparam int TP_W   = FCNT_W + FRM_W;
    localparam int HAVE_W = OFF_W + 1;
    localparam logic [PKT_W-1:0] HDR_P = PKT_W'(HEADER_BYTES);
    localparam logic [PKT_W-1:0] PMIN  = PKT_W'(HEADER_BYTES + 2);
    localparam logic [SRC_W-1:0] HDR_S = SRC_W'(HEADER_BYTES);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL      = 7'b0000010,
        ST_MOD_GO   = 7'b0000100,
        ST_MOD_WAIT = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_PLACE    = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;

    // Effective register values, registered
    logic [PKT_W-1:0]   pk_sat, p_diff;
    logic [FRM_W-1:0]   f_sat;
    logic [FCNT_W-1:0]  n_sat;
    logic [TP_W-1:0]    tot_prod;
    logic [LEN_W-1:0]   p_reg;
    logic [FRM_W-1:0]   f_reg;
    logic [OFF_W-1:0]   total_reg;

    // Per-packet working registers
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [SEQ_W-1:0]   k_reg, k_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [LEN_W-1:0]   r_reg, r_next;

    // Capture state
    logic               synced_reg, synced_next;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [OFF_W-1:0]   expect_reg, expect_next;
    logic [OFF_W-1:0]   arrive_reg, arrive_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg, res_w;
    logic               wr;

    // Helpers
    logic [SEQ_W-1:0]     mul_a;
    logic [DIV_DVS_W-1:0] r_cand;
    logic                 hit;
    logic [LEN_W-1:0]     plen, first_len;
    logic [OFF_W-1:0]     e_q, e_m1, arr_new;
    logic                 in_range, last_pkt, cap_done;
    logic [HAVE_W-1:0]    have;
    logic [PROD_W-1:0]    have_ext, len_raw;
    logic [LEN_W-1:0]     len_last;

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Saturate the register values
    always_comb
    begin
        if (cfg.packet_bytes < PMIN)
        begin
            pk_sat = PMIN;
        end
        else if (cfg.packet_bytes > PKT_MAX)
        begin
            pk_sat = PKT_MAX;
        end
        else
        begin
            pk_sat = cfg.packet_bytes;
        end
        if (cfg.frame_bytes == '0)
        begin
            f_sat = FRM_W'(1);
        end
        else if (cfg.frame_bytes > FRAME_MAX)
        begin
            f_sat = FRAME_MAX;
        end
        else
        begin
            f_sat = cfg.frame_bytes;
        end
        n_sat    = (cfg.frame_count == '0) ? FCNT_W'(1) : cfg.frame_count;
        p_diff   = pk_sat - HDR_P;
        tot_prod = TP_W'(n_sat) * TP_W'(f_sat);
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_diff[LEN_W-1:0];
        f_reg     <= f_sat;
        total_reg <= tot_prod[OFF_W-1:0];
    end

    // Datapath helpers
    always_comb
    begin
        mul_a     = synced_reg ? (seq_reg - base_reg) : (seq_reg - SEQ_W'(1));
        prod_next = PROD_W'(mul_a) * PROD_W'(p_reg);

        // leading bytes of the previous frame in this payload
        r_cand = (div_rsp.rem == '0) ? '0 : (f_reg - div_rsp.rem);
        hit    = r_cand < DIV_DVS_W'(p_reg);

        plen      = p_reg - r_reg;
        first_len = (OFF_W'(plen) > total_reg) ? total_reg[LEN_W-1:0] : plen;
        e_q       = div_rsp.quo[OFF_W-1:0];

        e_m1     = expect_reg - OFF_W'(1);
        in_range = (k_reg != '0) && (expect_reg != '0) && (k_reg <= e_m1);
        last_pkt = (k_reg == e_m1);
        have     = HAVE_W'(total_reg) + HAVE_W'(remain_reg);
        have_ext = PROD_W'(have);
        len_raw  = (have_ext > prod_reg) ? (have_ext - prod_reg) : '0;
        len_last = (len_raw > PROD_W'(p_reg)) ? p_reg : len_raw[LEN_W-1:0];
        arr_new  = arrive_reg + OFF_W'(1);
        cap_done = (arr_new >= expect_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        synced_next    = synced_reg;
        base_next      = base_reg;
        remain_next    = remain_reg;
        expect_next    = expect_reg;
        arrive_next    = arrive_reg;
        q_pop          = 1'b0;
        div_req        = '0;
        wr             = 1'b0;
        res_w          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // take a beat only once the result slot is free
                if (!q_empty && (!out_valid_reg || res_pop))
                begin
                    q_pop = 1'b1;
                    if (!q_item.work)
                    begin
                        wr = 1'b1;
                    end
                    else
                    begin
                        seq_next   = q_item.seq;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                k_next     = mul_a;
                state_next = synced_reg ? ST_PLACE : ST_MOD_GO;
            end
            ST_MOD_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_DVD_W'(prod_reg);
                div_req.divisor  = f_reg;
                state_next       = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (hit)
                    begin
                        r_next     = r_cand[LEN_W-1:0];
                        state_next = ST_DIV_GO;
                    end
                    else
                    begin
                        wr         = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV_GO:
            begin
                // ceiling of (R + N*F) / P
                div_req.start    = 1'b1;
                div_req.dividend = DIV_DVD_W'(r_reg) + DIV_DVD_W'(total_reg)
                                 + DIV_DVD_W'(p_reg) - DIV_DVD_W'(1);
                div_req.divisor  = DIV_DVS_W'(p_reg);
                state_next       = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    base_next         = seq_reg;
                    remain_next       = r_reg;
                    expect_next       = e_q;
                    arrive_next       = OFF_W'(1);
                    synced_next       = (e_q > OFF_W'(1));
                    wr                = 1'b1;
                    res_w.place_valid = 1'b1;
                    res_w.synced_now  = 1'b1;
                    res_w.src_offset  = HDR_S + r_reg;
                    res_w.copy_length = first_len;
                    res_w.capture_done = (e_q <= OFF_W'(1));
                    state_next        = ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                arrive_next = arr_new;
                wr          = 1'b1;
                if (in_range)
                begin
                    res_w.place_valid = 1'b1;
                    res_w.dest_offset = prod_reg[OFF_W-1:0] - OFF_W'(remain_reg);
                    res_w.src_offset  = HDR_S;
                    res_w.copy_length = last_pkt ? len_last : p_reg;
                end
                if (cap_done)
                begin
                    res_w.capture_done = 1'b1;
                    synced_next        = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result slot
        out_valid_next = out_valid_reg;
        if (wr)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            synced_reg    <= 1'b0;
            base_reg      <= '0;
            remain_reg    <= '0;
            expect_reg    <= '0;
            arrive_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            synced_reg    <= synced_next;
            base_reg      <= base_next;
            remain_reg    <= remain_next;
            expect_reg    <= expect_next;
            arrive_reg    <= arrive_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        k_reg   <= k_next;
        r_reg   <= r_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (wr)
        begin
            res_reg <= res_w;
        end
    end

endmodule

`default_nettype wire

// File: rtl/frame_aligned_packet_placer.sv
// Frame aligned packet placer: top level with configuration registers.
// Ignored beats go straight to the result slot; a capture beat passes the multiply and
// place states; a sync search runs a modulo on the shared divider, and a capture start a
// ceiling division too, at 3 quotient bits per cycle over a 48-bit dividend. The engine
// handles one beat at a time while the input stage and queue take new beats until full.
// Asynchronous active-low reset: searching, queues empty, registers at their defaults.
`default_nettype none
`include "frame_aligned_packet_placer_assert.svh"

module frame_aligned_packet_placer #(
    parameter int unsigned HEADER_BYTES = fapp_pkg::HEADER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [fapp_pkg::SEQ_W-1:0]       seq_num,
    output logic                             empty,
    input  logic                             pop,
    output logic                             place_valid,
    output logic [fapp_pkg::OFF_W-1:0]       dest_offset,
    output logic [fapp_pkg::SRC_W-1:0]       src_offset,
    output logic [fapp_pkg::LEN_W-1:0]       copy_length,
    output logic                             synced_now,
    output logic                             capture_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fapp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fapp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fapp_pkg::*;

    cfg_t     cfg_reg;
    logic     front_valid;
    item_t    front_item;
    logic     q_full, q_empty, q_wr, q_pop;
    item_t    q_item;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     res_valid;
    res_t     res;

    // Configuration registers; writes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packet_bytes <= PKT_RST;
            cfg_reg.frame_bytes  <= FRM_RST;
            cfg_reg.frame_count  <= FCNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PACKET_BYTES: cfg_reg.packet_bytes <= cfg_data[PKT_W-1:0];
                REG_FRAME_BYTES:  cfg_reg.frame_bytes  <= cfg_data[FRM_W-1:0];
                REG_FRAME_COUNT:  cfg_reg.frame_count  <= cfg_data[FCNT_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Front: input stage and queue
    fapp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .seq_num    (seq_num),
        .cfg        (cfg_reg),
        .full       (full),
        .item_valid (front_valid),
        .item       (front_item),
        .sink_ready (!q_full)
    );

    assign q_wr = front_valid && !q_full;

    fapp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_item (front_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    // Back: divider and placement engine
    fapp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fapp_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty        = !res_valid;
    assign place_valid  = res.place_valid;
    assign dest_offset  = res.dest_offset;
    assign src_offset   = res.src_offset;
    assign copy_length  = res.copy_length;
    assign synced_now   = res.synced_now;
    assign capture_done = res.capture_done;

    // Checks
    `FAPP_ASSERT_IMP(a_skip_is_zero, !empty && !place_valid,
        dest_offset == '0 && src_offset == '0 && copy_length == '0,
        "skipped beat carries a nonzero placement")
    `FAPP_ASSERT_IMP(a_sync_places_at_zero, !empty && synced_now,
        place_valid && dest_offset == '0, "sync beat not placed at offset zero")
    `FAPP_ASSERT_IMP(a_src_past_header, !empty && place_valid,
        src_offset >= SRC_W'(HEADER_BYTES), "copy starts inside the header")
    `FAPP_ASSERT_NXT(a_no_false_full, q_empty && !front_valid, !full,
        "input reports full with an empty queue")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for frame_aligned_packet_placer: directed table, then random captures.
// Depends on fapp_pkg and the placer RTL; expected placements come from an in-bench model.
`timescale 1ns / 100ps

module tb_top;

    import fapp_pkg::*;

    localparam int unsigned HDR        = HEADER_BYTES_DEF;
    localparam int unsigned RUN_LIMIT  = 400000;
    localparam int unsigned TAIL_WAIT  = 60;
    localparam int unsigned PHASES     = 8;
    localparam int unsigned PHASE_PKTS = 64;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam res_t NO_PLACE = '0;

    typedef enum bit {ROW_PACKET, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [SEQ_W-1:0]      value;
        bit                    typed;
        res_t                  want;
    } plan_row_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [SEQ_W-1:0]      seq_num   = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic                  place_valid;
    logic [OFF_W-1:0]      dest_offset;
    logic [SRC_W-1:0]      src_offset;
    logic [LEN_W-1:0]      copy_length;
    logic                  synced_now;
    logic                  capture_done;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register shadow, as the block sees it
    logic [PKT_W-1:0]  pkt_reg  = PKT_RST;
    logic [FRM_W-1:0]  frm_reg  = FRM_RST;
    logic [FCNT_W-1:0] fcnt_reg = FCNT_RST;

    // Capture tracking state
    bit               in_capture     = 1'b0;
    logic [31:0]      base_seq       = '0;
    logic [12:0]      lead_bytes     = '0;
    logic [31:0]      packets_needed = '0;
    logic [31:0]      arrivals_seen  = '0;
    logic [31:0]      next_k         = '0;

    res_t             placement_q[$];
    plan_row_t        plan_rows[$];

    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      mismatches     = 0;
    int unsigned      packets_sent   = 0;
    int unsigned      ignored_sent   = 0;
    int unsigned      data_checked   = 0;
    int unsigned      opened         = 0;
    int unsigned      closed         = 0;
    int unsigned      reg_writes     = 0;
    int unsigned      cycle_count    = 0;

    frame_aligned_packet_placer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .seq_num      (seq_num),
        .empty        (empty),
        .pop          (pop),
        .place_valid  (place_valid),
        .dest_offset  (dest_offset),
        .src_offset   (src_offset),
        .copy_length  (copy_length),
        .synced_now   (synced_now),
        .capture_done (capture_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic bit roll_pct(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Payload size after saturation of packet_bytes
    function automatic longint unsigned eff_payload();
        longint unsigned p;
        p = pkt_reg;
        if (p < HDR + 2) p = HDR + 2;
        if (p > PKT_MAX) p = PKT_MAX;
        return p - HDR;
    endfunction

    function automatic longint unsigned eff_frame();
        longint unsigned f;
        f = frm_reg;
        if (f < 1) f = 1;
        if (f > FRAME_MAX) f = FRAME_MAX;
        return f;
    endfunction

    // Bytes at the head of this packet's payload that close the previous frame
    function automatic longint unsigned leading_bytes(input logic [31:0] s,
                                                      input longint unsigned p,
                                                      input longint unsigned f);
        longint unsigned sx;
        longint unsigned moved;
        sx    = s;
        moved = (sx - 1) * p;
        return (f - moved % f) % f;
    endfunction

    function automatic res_t place(input bit v, input logic [31:0] d, input logic [12:0] s,
                                   input logic [12:0] l, input bit now, input bit done);
        res_t r;
        r.place_valid  = v;
        r.dest_offset  = d;
        r.src_offset   = s;
        r.copy_length  = l;
        r.synced_now   = now;
        r.capture_done = done;
        return r;
    endfunction

    function automatic plan_row_t pkt_row(input logic [31:0] s, input bit typed, input res_t want);
        plan_row_t row;
        row.kind  = ROW_PACKET;
        row.idx   = '0;
        row.value = s;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        plan_row_t row;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = val;
        row.typed = 1'b0;
        row.want  = NO_PLACE;
        return row;
    endfunction

    // Placement model: updates capture state for one accepted packet
    task automatic predict_placement(input logic [31:0] s, output res_t r);
        longint unsigned p, f, n, total, k, lead, have, used, len;
        logic [31:0] diff;
        r = NO_PLACE;
        if (s != 32'd0 && !pkt_reg[0]) begin
            p     = eff_payload();
            f     = eff_frame();
            n     = (fcnt_reg == 0) ? 1 : fcnt_reg;
            total = n * f;
            if (!in_capture) begin
                lead = leading_bytes(s, p, f);
                if (lead < p) begin
                    in_capture     = 1'b1;
                    base_seq       = s;
                    lead_bytes     = lead[12:0];
                    packets_needed = 32'((lead + total + p - 1) / p);
                    arrivals_seen  = 32'd1;
                    next_k         = 32'd1;
                    opened++;
                    len = p - lead;
                    if (len > total) len = total;
                    r.place_valid = 1'b1;
                    r.src_offset  = 13'(HDR + lead);
                    r.copy_length = 13'(len);
                    r.synced_now  = 1'b1;
                end
            end else begin
                diff          = s - base_seq;
                k             = diff;
                arrivals_seen = arrivals_seen + 1;
                if (k >= 1 && packets_needed >= 1 && k <= packets_needed - 1) begin
                    r.place_valid = 1'b1;
                    r.dest_offset = 32'(k * p - lead_bytes);
                    r.src_offset  = 13'(HDR);
                    if (k == packets_needed - 1) begin
                        // last packet carries only what is left of the capture
                        have = total + lead_bytes;
                        used = k * p;
                        len  = (have > used) ? have - used : 0;
                        if (len > p) len = p;
                    end else begin
                        len = p;
                    end
                    r.copy_length = 13'(len);
                end
            end
            if (in_capture && arrivals_seen >= packets_needed) begin
                r.capture_done = 1'b1;
                in_capture     = 1'b0;
                closed++;
            end
        end
    endtask

    // Random packet: mostly the next packet of the capture, or a packet that starts one
    function automatic logic [31:0] choose_seq();
        logic [31:0]     s;
        int unsigned     roll;
        int unsigned     i;
        longint unsigned p, f;
        roll = $urandom_range(99);
        p    = eff_payload();
        f    = eff_frame();
        s    = $urandom;
        if (roll < 5) begin
            s = '0;
        end else if (in_capture) begin
            if (roll < 80) begin
                s      = base_seq + next_k;
                next_k = next_k + 1;
            end else if (roll < 90 && packets_needed > 1) begin
                s = base_seq + $urandom_range(1, packets_needed - 1);
            end else if (roll < 95) begin
                s = base_seq + packets_needed + $urandom_range(0, 3);
            end
        end else if (roll < 75) begin
            for (i = 0; i < 5000 && (s == 0 || leading_bytes(s, p, f) >= p); i++)
                s = s + 1;
        end
        return s;
    endfunction

    // One packet beat; push stays high afterwards unless the next action lowers it
    task automatic send_packet(input logic [31:0] s, output res_t pred);
        cfg_valid <= 1'b0;
        while (roll_pct(send_idle_pct)) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        seq_num <= s;
        @(posedge clk);
        while (full) @(posedge clk);
        packets_sent++;
        if (s == 0 || pkt_reg[0]) ignored_sent++;
        predict_placement(s, pred);
    endtask

    // Register write, only once every pending placement has come out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        push <= 1'b0;
        while (placement_q.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        reg_writes++;
        case (idx)
            REG_PACKET_BYTES: pkt_reg  = val[PKT_W-1:0];
            REG_FRAME_BYTES:  frm_reg  = val[FRM_W-1:0];
            REG_FRAME_COUNT:  fcnt_reg = val[FCNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Result side: check each popped beat, then decide next cycle's pop
    always @(posedge clk) begin : result_check
        res_t want;
        if (rst_n && pop && !empty) begin
            if (placement_q.size() == 0) begin
                $display("%0t: unexpected result beat, dest 0x%0h len %0d", $time,
                         dest_offset, copy_length);
                mismatches++;
            end else begin
                want = placement_q.pop_front();
                if (want.place_valid) data_checked++;
                compare_field("place_valid", want.place_valid, place_valid);
                compare_field("dest_offset", want.dest_offset, dest_offset);
                compare_field("src_offset", want.src_offset, src_offset);
                compare_field("copy_length", want.copy_length, copy_length);
                compare_field("synced_now", want.synced_now, synced_now);
                compare_field("capture_done", want.capture_done, capture_done);
            end
        end
        pop <= !roll_pct(recv_stall_pct);
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d placements still pending", $time, placement_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        plan_row_t       row;
        res_t            pred;
        logic [31:0]     s;
        int unsigned     phase;
        int unsigned     counted;
        int unsigned     fc, pkt, fb;
        int unsigned     idle_send[4];
        int unsigned     idle_recv[4];

        idle_send = '{0, 58, 0, 19};
        idle_recv = '{0, 0, 58, 19};

        // Directed table; registers start at their reset values
        plan_rows.push_back(pkt_row(32'd0, 1, NO_PLACE));           // sequence zero
        plan_rows.push_back(pkt_row(32'd2, 1, NO_PLACE));           // no frame start
        plan_rows.push_back(reg_row(REG_PACKET_BYTES, 13));         // odd length
        plan_rows.push_back(pkt_row(32'd1, 1, NO_PLACE));
        plan_rows.push_back(reg_row(REG_PACKET_BYTES, 12));         // two-byte payload
        plan_rows.push_back(reg_row(REG_FRAME_BYTES, 4));
        plan_rows.push_back(reg_row(REG_FRAME_COUNT, 0));           // zero used as one
        plan_rows.push_back(pkt_row(32'd1, 1, place(1, 0, 10, 2, 1, 0)));
        plan_rows.push_back(pkt_row(32'd3, 1, place(0, 0, 0, 0, 0, 1)));  // out of range, done
        plan_rows.push_back(pkt_row(32'd2, 1, NO_PLACE));           // lead equal to payload
        plan_rows.push_back(pkt_row(32'd3, 1, place(1, 0, 10, 2, 1, 0)));
        plan_rows.push_back(reg_row(REG_PACKET_BYTES, 20));         // change mid capture
        plan_rows.push_back(pkt_row(32'd4, 0, NO_PLACE));
        plan_rows.push_back(reg_row(REG_PACKET_BYTES, 2));          // saturates low
        plan_rows.push_back(reg_row(REG_FRAME_BYTES, 0));           // saturates to one
        plan_rows.push_back(pkt_row(32'h8000_0000, 1, place(1, 0, 10, 1, 1, 1)));  // one packet
        plan_rows.push_back(reg_row(REG_PACKET_BYTES, 16382));      // saturates high
        plan_rows.push_back(reg_row(REG_FRAME_BYTES, 32'h1FF_FFFF));
        plan_rows.push_back(reg_row(REG_FRAME_COUNT, 255));
        plan_rows.push_back(pkt_row(32'hFFFF_FFFF, 0, NO_PLACE));
        plan_rows.push_back(pkt_row(32'd2, 0, NO_PLACE));
        plan_rows.push_back(reg_row(REG_SPARE, 32'h155_5555));      // unmapped index
        plan_rows.push_back(reg_row(REG_PACKET_BYTES, 8192));
        plan_rows.push_back(reg_row(REG_FRAME_BYTES, 16777216));
        plan_rows.push_back(pkt_row(32'h0100_0000, 0, NO_PLACE));
        plan_rows.push_back(reg_row(REG_PACKET_BYTES, 32'(PKT_RST)));
        plan_rows.push_back(reg_row(REG_FRAME_BYTES, 32'(FRM_RST)));
        plan_rows.push_back(reg_row(REG_FRAME_COUNT, 32'(FCNT_RST)));
        plan_rows.push_back(pkt_row(32'd1, 1, place(1, 0, 10, 1456, 1, 0)));
        plan_rows.push_back(pkt_row(32'd46, 1, place(1, 65520, 10, 16, 0, 0)));  // last packet

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i]) begin
            row = plan_rows[i];
            if (row.kind == ROW_REG) begin
                write_reg(row.idx, row.value);
            end else begin
                send_packet(row.value, pred);
                placement_q.push_back(row.typed ? row.want : pred);
            end
        end

        // Random captures over several settings and idle patterns
        for (phase = 0; phase < PHASES; phase++) begin
            send_idle_pct  = idle_send[phase % 4];
            recv_stall_pct = idle_recv[phase % 4];
            fc  = $urandom_range(0, 3);
            pkt = (phase == 3) ? 12 : 2 * $urandom_range(6, 600);
            fb  = $urandom_range(1, (pkt - HDR) * 6 / ((fc == 0) ? 1 : fc));
            write_reg(REG_PACKET_BYTES, pkt);
            write_reg(REG_FRAME_BYTES, fb);
            write_reg(REG_FRAME_COUNT, fc);
            counted = 0;
            while (counted < PHASE_PKTS) begin
                s = choose_seq();
                send_packet(s, pred);
                placement_q.push_back(pred);
                if (s != 0) counted++;
            end
        end

        push <= 1'b0;
        while (placement_q.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Sent %0d packets (%0d ignored), %0d register writes, %0d cycles.",
                 packets_sent, ignored_sent, reg_writes, cycle_count);
        $display("Captures opened %0d, closed %0d; %0d data placements checked.",
                 opened, closed, data_checked);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
